### rtl/core/crc_checked_block_receiver_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the CRC-checked block receiver core.
// Clocked, reset-qualified concurrent assertions used by the core modules.
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_BLOCK_RECEIVER_CORE_DEFINES_SVH
`define CRC_CHECKED_BLOCK_RECEIVER_CORE_DEFINES_SVH

// Assertion on an explicit clock and active-low reset.
`define CRBR_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the core clock and reset.
`define CRBR_ASSERT(label, prop, msg) \
  `CRBR_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

### rtl/core/crbr_pkg.sv
// ----------------------------------------------------------------------------
// crbr_pkg
// Shared types, codes, constants and the CRC-16 byte update for the receiver.
// ----------------------------------------------------------------------------
package crbr_pkg;

  localparam int BLOCK_MAX_DEF = 1024;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int POS_W      = 12;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] TICK_SAT = 16'hFFFF;

  localparam logic [10:0] BLOCK_LENGTH_RST  = 11'd1024;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd2000;
  localparam logic [2:0]  MAX_TRIES_RST     = 3'd4;
  localparam logic [2:0]  TRY_SAT           = 3'd7;

  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_LENGTH       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT_TICKS      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_TRIES          = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_READY_CODE         = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_CODE        = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_ABORT_CODE         = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT_ABORT_CODE = 3'd6;

  localparam logic [1:0] ST_BUSY    = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_BAD_CRC = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic {
    PH_IDLE = 1'b0,
    PH_RX   = 1'b1
  } phase_e;

  typedef struct packed {
    logic       send_byte;
    logic [7:0] tx_byte;
    logic [1:0] status;
    logic       finished;
    logic       is_read;
    logic       rd_zero;
  } res_t;

  typedef struct packed {
    logic       we;
    logic       re;
    logic [7:0] wdata;
  } mem_req_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### rtl/core/crbr_store.sv
// ----------------------------------------------------------------------------
// crbr_store
// Payload byte memory with one write and one registered read per cycle, both at one address.
// ----------------------------------------------------------------------------
module crbr_store #(
  parameter int BlockMax = crbr_pkg::BLOCK_MAX_DEF,
  parameter int AddrW    = $clog2(BlockMax)
) (
  input  logic                clk_i,
  input  crbr_pkg::mem_req_t  req_i,
  input  logic [AddrW-1:0]    addr_i,
  output logic [7:0]          rdata_o
);

  logic [7:0] mem [BlockMax];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[addr_i] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/crbr_ctrl.sv
// ----------------------------------------------------------------------------
// crbr_ctrl
// Configuration registers, attempt sequencer, running CRC and store access.
// ----------------------------------------------------------------------------
`include "crc_checked_block_receiver_core_defines.svh"

module crbr_ctrl #(
  parameter int BlockMax = crbr_pkg::BLOCK_MAX_DEF,
  parameter int AddrW    = $clog2(BlockMax)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [crbr_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [crbr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_fire_i,
  input  crbr_pkg::op_e                     op_i,
  input  logic [7:0]                        rx_byte_i,
  input  logic [9:0]                        read_index_i,
  output crbr_pkg::mem_req_t                mem_req_o,
  output logic [AddrW-1:0]                  mem_addr_o,
  output logic                              res_valid_o,
  output crbr_pkg::res_t                    res_o
);

  localparam int LenCap = (BlockMax < 2047) ? BlockMax : 2047;

  logic [10:0] block_length_q;
  logic [15:0] timeout_ticks_q;
  logic [2:0]  max_tries_q;
  logic [7:0]  ready_code_q, repeat_code_q, abort_code_q, timeout_abort_code_q;

  crbr_pkg::phase_e phase_q, phase_d;
  logic [crbr_pkg::POS_W-1:0] pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rcrc_q, rcrc_d;
  logic [2:0]  try_q, try_d;
  logic [15:0] tick_q, tick_d;

  logic [10:0] eff_len;
  logic [crbr_pkg::POS_W-1:0] len_ext;
  logic [15:0] tick_inc, crc_full;
  logic [2:0]  try_inc, try_limit;
  logic        rd_in_range;
  logic ev_start, ev_read, ev_tick, ev_timeout, ev_payload, ev_crc_hi;
  logic ev_ok, ev_retry, ev_abort;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_length_q       <= crbr_pkg::BLOCK_LENGTH_RST;
      timeout_ticks_q      <= crbr_pkg::TIMEOUT_TICKS_RST;
      max_tries_q          <= crbr_pkg::MAX_TRIES_RST;
      ready_code_q         <= 8'h00;
      repeat_code_q        <= 8'h00;
      abort_code_q         <= 8'h00;
      timeout_abort_code_q <= 8'h00;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        crbr_pkg::REG_BLOCK_LENGTH:       block_length_q       <= cfg_data_i[10:0];
        crbr_pkg::REG_TIMEOUT_TICKS:      timeout_ticks_q      <= cfg_data_i;
        crbr_pkg::REG_MAX_TRIES:          max_tries_q          <= cfg_data_i[2:0];
        crbr_pkg::REG_READY_CODE:         ready_code_q         <= cfg_data_i[7:0];
        crbr_pkg::REG_REPEAT_CODE:        repeat_code_q        <= cfg_data_i[7:0];
        crbr_pkg::REG_ABORT_CODE:         abort_code_q         <= cfg_data_i[7:0];
        crbr_pkg::REG_TIMEOUT_ABORT_CODE: timeout_abort_code_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (block_length_q == 11'd0) begin
      eff_len = 11'd1;
    end else if (block_length_q > 11'(LenCap)) begin
      eff_len = 11'(LenCap);
    end else begin
      eff_len = block_length_q;
    end
  end

  assign len_ext     = {1'b0, eff_len};
  assign tick_inc    = (tick_q == crbr_pkg::TICK_SAT) ? tick_q : tick_q + 16'd1;
  assign crc_full    = rcrc_q | {8'h00, rx_byte_i};
  assign try_inc     = (try_q == crbr_pkg::TRY_SAT) ? try_q : try_q + 3'd1;
  assign try_limit   = (max_tries_q == 3'd0) ? 3'd1 : max_tries_q;
  assign rd_in_range = ({22'd0, read_index_i} < 32'(BlockMax));

  // Event decode.
  always_comb begin
    ev_start   = 1'b0;
    ev_read    = 1'b0;
    ev_tick    = 1'b0;
    ev_timeout = 1'b0;
    ev_payload = 1'b0;
    ev_crc_hi  = 1'b0;
    ev_ok      = 1'b0;
    ev_retry   = 1'b0;
    ev_abort   = 1'b0;
    if (in_fire_i) begin
      unique case (op_i)
        crbr_pkg::OP_START: ev_start = 1'b1;
        crbr_pkg::OP_READ:  ev_read  = 1'b1;
        crbr_pkg::OP_TICK: begin
          if (phase_q == crbr_pkg::PH_RX) begin
            if (tick_inc >= timeout_ticks_q) begin
              ev_timeout = 1'b1;
            end else begin
              ev_tick = 1'b1;
            end
          end
        end
        crbr_pkg::OP_BYTE: begin
          if (phase_q == crbr_pkg::PH_RX) begin
            priority if (pos_q < len_ext) begin
              ev_payload = 1'b1;
            end else if (pos_q == len_ext) begin
              ev_crc_hi = 1'b1;
            end else if (crc_full == crc_q) begin
              ev_ok = 1'b1;
            end else if (try_inc < try_limit) begin
              ev_retry = 1'b1;
            end else begin
              ev_abort = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    priority if (ev_start || ev_retry) begin
      phase_d = crbr_pkg::PH_RX;
    end else if (ev_timeout || ev_ok || ev_abort) begin
      phase_d = crbr_pkg::PH_IDLE;
    end else begin
      phase_d = phase_q;
    end
  end

  // Attempt state, store access and result.
  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    rcrc_d      = rcrc_q;
    try_d       = try_q;
    tick_d      = tick_q;
    mem_req_o   = '0;
    mem_addr_o  = ev_read ? AddrW'(read_index_i) : AddrW'(pos_q);
    res_valid_o = ev_start | ev_read | ev_timeout | ev_ok | ev_retry | ev_abort;
    res_o       = '0;

    if (ev_tick || ev_timeout) begin
      tick_d = tick_inc;
    end
    if (ev_payload) begin
      mem_req_o.we    = 1'b1;
      mem_req_o.wdata = rx_byte_i;
      crc_d           = crbr_pkg::crc16_byte(crc_q, rx_byte_i);
      pos_d           = pos_q + 1'b1;
    end
    if (ev_crc_hi) begin
      rcrc_d = {rx_byte_i, 8'h00};
      pos_d  = pos_q + 1'b1;
    end
    if (ev_ok || ev_retry || ev_abort) begin
      rcrc_d = crc_full;
    end
    if (ev_retry || ev_abort) begin
      try_d = try_inc;
    end
    if (ev_start) begin
      try_d = 3'd0;
    end
    if (ev_start || ev_retry) begin
      pos_d  = '0;
      crc_d  = crbr_pkg::CRC_INIT;
      rcrc_d = 16'h0000;
      tick_d = 16'h0000;
    end

    if (ev_read) begin
      mem_req_o.re  = rd_in_range;
      res_o.is_read = 1'b1;
      res_o.rd_zero = !rd_in_range;
    end
    if (ev_start) begin
      res_o.send_byte = 1'b1;
      res_o.tx_byte   = ready_code_q;
    end
    if (ev_retry) begin
      res_o.send_byte = 1'b1;
      res_o.tx_byte   = repeat_code_q;
    end
    if (ev_abort) begin
      res_o.send_byte = 1'b1;
      res_o.tx_byte   = abort_code_q;
      res_o.status    = crbr_pkg::ST_BAD_CRC;
      res_o.finished  = 1'b1;
    end
    if (ev_timeout) begin
      res_o.send_byte = 1'b1;
      res_o.tx_byte   = timeout_abort_code_q;
      res_o.status    = crbr_pkg::ST_TIMEOUT;
      res_o.finished  = 1'b1;
    end
    if (ev_ok) begin
      res_o.status   = crbr_pkg::ST_OK;
      res_o.finished = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= crbr_pkg::PH_IDLE;
      pos_q   <= '0;
      crc_q   <= crbr_pkg::CRC_INIT;
      rcrc_q  <= 16'h0000;
      try_q   <= 3'd0;
      tick_q  <= 16'h0000;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      rcrc_q  <= rcrc_d;
      try_q   <= try_d;
      tick_q  <= tick_d;
    end
  end

  `CRBR_ASSERT(a_write_in_rx, mem_req_o.we |-> (phase_q == crbr_pkg::PH_RX), "store written outside an attempt")
  `CRBR_ASSERT(a_start_opens, ev_start |=> ((phase_q == crbr_pkg::PH_RX) && (pos_q == '0)), "start did not open a fresh attempt")
  `CRBR_ASSERT(a_write_in_block, mem_req_o.we |-> (pos_q < len_ext), "store written beyond the payload")

endmodule

### rtl/core/crbr_out.sv
// ----------------------------------------------------------------------------
// crbr_out
// Result stage that joins the store read data, followed by an output buffer.
// ----------------------------------------------------------------------------
`include "crc_checked_block_receiver_core_defines.svh"

module crbr_out (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               res_valid_i,
  input  crbr_pkg::res_t                     res_i,
  input  logic [7:0]                         rdata_i,
  output logic                               in_ready_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [crbr_pkg::OUT_DATA_W-1:0]    out_data_o
);

  logic           p_valid_q, p_valid_d;
  crbr_pkg::res_t p_res_q;
  logic           o_valid_q, o_valid_d;
  logic [crbr_pkg::OUT_DATA_W-1:0] o_word_q, o_word_d;
  logic           p_move;
  logic [7:0]     read_data;

  assign p_move     = !o_valid_q || out_ready_i;
  assign in_ready_o = !p_valid_q || p_move;
  assign read_data  = (p_res_q.is_read && !p_res_q.rd_zero) ? rdata_i : 8'h00;

  always_comb begin
    p_valid_d = p_valid_q;
    if (res_valid_i) begin
      p_valid_d = 1'b1;
    end else if (p_move) begin
      p_valid_d = 1'b0;
    end
  end

  always_comb begin
    o_valid_d = o_valid_q;
    o_word_d  = o_word_q;
    if (p_valid_q && p_move) begin
      o_valid_d = 1'b1;
      o_word_d  = {4'h0, read_data, p_res_q.finished, p_res_q.status, p_res_q.tx_byte,
                   p_res_q.send_byte};
    end else if (out_ready_i) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      p_res_q <= res_i;
    end
    o_word_q <= o_word_d;
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_word_q;

  `CRBR_ASSERT(a_res_room, res_valid_i |-> (!p_valid_q || p_move), "result arrived with no room")
  `CRBR_ASSERT(a_res_held, (p_valid_q && !p_move) |=> (p_valid_q && $stable(p_res_q)), "waiting result lost")

endmodule

### rtl/core/crc_checked_block_receiver_core.sv
// ----------------------------------------------------------------------------
// crc_checked_block_receiver_core
// Block receiver with CRC-16 check, retry, timeout and payload read-back.
// ----------------------------------------------------------------------------
//   Channel   Direction  Ports                    Contents
//   s_axis    in         tvalid tready tdata tuser  events: byte, tick, start, read
//   m_axis    out        tvalid tready tdata        one result per reporting event
//   cfg       in         valid ready addr data      register writes
//
// One event per cycle enters while s_axis_tready is high; results are registered.
// The single-port payload memory serves one byte write or one read per event.
// The payload memory is not cleared after reset; registers reset at once.
// A result waiting at the output does not stop the next event being taken;
// a second waiting result holds s_axis_tready low until m_axis drains.
// ----------------------------------------------------------------------------
module crc_checked_block_receiver_core #(
  parameter int BlockMax = crbr_pkg::BLOCK_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] rx_byte, [17:8] read_index, [23:18] zero
  input  logic [crbr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] op
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] send_byte, [8:1] tx_byte, [10:9] status, [11] finished, [19:12] read_data,
  // [23:20] zero
  output logic [crbr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [crbr_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [crbr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int AddrW = $clog2(BlockMax);

  logic               in_fire;
  crbr_pkg::mem_req_t mem_req;
  logic [AddrW-1:0]   mem_addr;
  logic [7:0]         rdata;
  logic               res_valid;
  crbr_pkg::res_t     res;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = s_axis_tvalid && s_axis_tready;

  crbr_ctrl #(
    .BlockMax (BlockMax),
    .AddrW    (AddrW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .in_fire_i    (in_fire),
    .op_i         (crbr_pkg::op_e'(s_axis_tuser)),
    .rx_byte_i    (s_axis_tdata[7:0]),
    .read_index_i (s_axis_tdata[17:8]),
    .mem_req_o    (mem_req),
    .mem_addr_o   (mem_addr),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  crbr_store #(
    .BlockMax (BlockMax),
    .AddrW    (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .addr_i  (mem_addr),
    .rdata_o (rdata)
  );

  crbr_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .rdata_i     (rdata),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

### tb/tb_crc_checked_block_receiver_core.sv
// ----------------------------------------------------------------------------
// Testbench for the CRC-checked block receiver core
// Streams byte, tick, start and read words into the core, including well-formed
// blocks with good and bad CRC, timeouts, abandoned attempts and random noise.
// The bench keeps its own model of the receiver state and compares every
// result word field by field. Register settings are changed between phases.
// Random stalls are applied on both streams, with one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_crc_checked_block_receiver_core;

  localparam int MEM_DEPTH    = crbr_pkg::BLOCK_MAX_DEF;
  localparam int CFG_AW       = crbr_pkg::CFG_ADDR_W;
  localparam int RANDOM_ITEMS = 1050;
  localparam int IDLE_PCT     = 35;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUEUE_AHEAD  = 40;
  localparam int LONG_LEN     = 200;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    crbr_pkg::op_e op;
    logic [7:0]    b;
    logic [9:0]    idx;
  } link_item_t;

  typedef struct {
    logic       send;
    logic [7:0] tx;
    logic [1:0] status;
    logic       fin;
    logic [7:0] data;
  } link_reply_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [crbr_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]                      s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [crbr_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [crbr_pkg::CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [crbr_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  crc_checked_block_receiver_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Register mirror.
  logic [10:0] blk_len    = crbr_pkg::BLOCK_LENGTH_RST;
  logic [15:0] tmo        = crbr_pkg::TIMEOUT_TICKS_RST;
  logic [2:0]  tries_max  = crbr_pkg::MAX_TRIES_RST;
  logic [7:0]  code_ready = 8'h00;
  logic [7:0]  code_rep   = 8'h00;
  logic [7:0]  code_abort = 8'h00;
  logic [7:0]  code_tmo   = 8'h00;

  // Receiver state mirror.
  logic [7:0]        payload_mem [MEM_DEPTH];
  bit                stored_flag [MEM_DEPTH];
  int                stored_pos [$];
  int                rx_pos = 0;
  logic [15:0]       run_crc = crbr_pkg::CRC_INIT;
  logic [15:0]       got_crc = 16'h0000;
  int                try_num = 0;
  int                tick_num = 0;
  crbr_pkg::phase_e  rx_phase = crbr_pkg::PH_IDLE;

  link_item_t  word_q [$];
  link_reply_t reply_q [$];

  int src_idle_pct = IDLE_PCT;
  int sink_idle_pct = IDLE_PCT;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  bit item_taken = 1'b0;
  int cycle_cnt = 0;
  int fails = 0;
  int words_in = 0;
  int results_seen = 0;
  int gen_count = 0;
  int phases = 0;
  int reg_writes = 0;

  link_item_t  drv_item;
  link_item_t  mon_item;
  link_reply_t want;
  link_reply_t seen;
  link_reply_t pred;

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      fb = c[15];
      c = c << 1;
      if (fb) begin
        c = c ^ 16'h1021;
      end
    end
    return c;
  endfunction

  function automatic int payload_len();
    if (blk_len == 11'd0) begin
      return 1;
    end
    if (blk_len > 11'(MEM_DEPTH)) begin
      return MEM_DEPTH;
    end
    return int'(blk_len);
  endfunction

  function automatic void open_attempt();
    rx_pos = 0;
    run_crc = crbr_pkg::CRC_INIT;
    got_crc = 16'h0000;
    tick_num = 0;
    rx_phase = crbr_pkg::PH_RX;
  endfunction

  function automatic bit advance_receiver(input link_item_t it, output link_reply_t r);
    int len;
    int lim;
    r = '{send: 1'b0, tx: 8'h00, status: crbr_pkg::ST_BUSY, fin: 1'b0, data: 8'h00};
    case (it.op)
      crbr_pkg::OP_START: begin
        try_num = 0;
        open_attempt();
        r.send = 1'b1;
        r.tx = code_ready;
        return 1'b1;
      end
      crbr_pkg::OP_READ: begin
        r.data = payload_mem[it.idx];
        return 1'b1;
      end
      crbr_pkg::OP_TICK: begin
        if (rx_phase != crbr_pkg::PH_RX) begin
          return 1'b0;
        end
        if (tick_num < 32'hFFFF) begin
          tick_num++;
        end
        if (tick_num >= int'(tmo)) begin
          rx_phase = crbr_pkg::PH_IDLE;
          r.send = 1'b1;
          r.tx = code_tmo;
          r.status = crbr_pkg::ST_TIMEOUT;
          r.fin = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        if (rx_phase != crbr_pkg::PH_RX) begin
          return 1'b0;
        end
        len = payload_len();
        if (rx_pos < len) begin
          payload_mem[rx_pos] = it.b;
          if (!stored_flag[rx_pos]) begin
            stored_flag[rx_pos] = 1'b1;
            stored_pos.push_back(rx_pos);
          end
          run_crc = crc_step(run_crc, it.b);
          rx_pos++;
          return 1'b0;
        end
        if (rx_pos == len) begin
          got_crc = {it.b, 8'h00};
          rx_pos++;
          return 1'b0;
        end
        got_crc = got_crc | {8'h00, it.b};
        if (run_crc == got_crc) begin
          rx_phase = crbr_pkg::PH_IDLE;
          r.status = crbr_pkg::ST_OK;
          r.fin = 1'b1;
          return 1'b1;
        end
        lim = (tries_max == 3'd0) ? 1 : int'(tries_max);
        if (try_num < int'(crbr_pkg::TRY_SAT)) begin
          try_num++;
        end
        r.send = 1'b1;
        if (try_num < lim) begin
          open_attempt();
          r.tx = code_rep;
          return 1'b1;
        end
        rx_phase = crbr_pkg::PH_IDLE;
        r.tx = code_abort;
        r.status = crbr_pkg::ST_BAD_CRC;
        r.fin = 1'b1;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic compare_field(input string name, input logic [7:0] e, input logic [7:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      fails++;
    end
  endtask

  // Input and output monitor with prediction.
  always @(posedge clk_i) begin
    item_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (item_taken) begin
      mon_item.op = crbr_pkg::op_e'(s_axis_tuser);
      mon_item.b = s_axis_tdata[7:0];
      mon_item.idx = s_axis_tdata[17:8];
      words_in++;
      if (advance_receiver(mon_item, pred)) begin
        reply_q.push_back(pred);
      end
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.send = m_axis_tdata[0];
      seen.tx = m_axis_tdata[8:1];
      seen.status = m_axis_tdata[10:9];
      seen.fin = m_axis_tdata[11];
      seen.data = m_axis_tdata[19:12];
      results_seen++;
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, m_axis_tdata);
        fails++;
      end else begin
        want = reply_q.pop_front();
        compare_field("send_byte", 8'(want.send), 8'(seen.send));
        compare_field("tx_byte", want.tx, seen.tx);
        compare_field("status", 8'(want.status), 8'(seen.status));
        compare_field("finished", 8'(want.fin), 8'(seen.fin));
        compare_field("read_data", want.data, seen.data);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || item_taken)) begin
      if (word_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        drv_item = word_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, drv_item.idx, drv_item.b};
        s_axis_tuser <= drv_item.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_cnt = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(7);
    if (r == 0) begin
      return 8'h00;
    end
    if (r == 1) begin
      return 8'hFF;
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic void add_item(input crbr_pkg::op_e op, input logic [7:0] b,
                                   input logic [9:0] idx);
    link_item_t it;
    it.op = op;
    it.b = b;
    it.idx = idx;
    word_q.push_back(it);
    gen_count++;
  endfunction

  // Reads only go to entries that an accepted byte word has already written.
  function automatic void add_read();
    if (stored_pos.size() == 0) begin
      add_item(crbr_pkg::OP_TICK, rand_byte(), 10'($urandom_range(1023)));
    end else begin
      add_item(crbr_pkg::OP_READ, rand_byte(),
               10'(stored_pos[$urandom_range(stored_pos.size() - 1)]));
    end
  endfunction

  task automatic write_reg(input logic [crbr_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [crbr_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      crbr_pkg::REG_BLOCK_LENGTH:       blk_len = val[10:0];
      crbr_pkg::REG_TIMEOUT_TICKS:      tmo = val;
      crbr_pkg::REG_MAX_TRIES:          tries_max = val[2:0];
      crbr_pkg::REG_READY_CODE:         code_ready = val[7:0];
      crbr_pkg::REG_REPEAT_CODE:        code_rep = val[7:0];
      crbr_pkg::REG_ABORT_CODE:         code_abort = val[7:0];
      crbr_pkg::REG_TIMEOUT_ABORT_CODE: code_tmo = val[7:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    while (word_q.size() != 0 || s_axis_tvalid || reply_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic pick_settings();
    int r;
    settle();
    if ($urandom_range(1)) begin
      r = $urandom_range(19);
      case (r)
        0: write_reg(crbr_pkg::REG_BLOCK_LENGTH, 16'd0);
        1: write_reg(crbr_pkg::REG_BLOCK_LENGTH, 16'd1);
        2: write_reg(crbr_pkg::REG_BLOCK_LENGTH, 16'd1024);
        3: write_reg(crbr_pkg::REG_BLOCK_LENGTH, 16'd2047);
        default: write_reg(crbr_pkg::REG_BLOCK_LENGTH, 16'($urandom_range(2, 20)));
      endcase
    end
    if ($urandom_range(1)) begin
      r = $urandom_range(15);
      case (r)
        0: write_reg(crbr_pkg::REG_TIMEOUT_TICKS, 16'd0);
        1: write_reg(crbr_pkg::REG_TIMEOUT_TICKS, 16'd1);
        2: write_reg(crbr_pkg::REG_TIMEOUT_TICKS, 16'hFFFF);
        3: write_reg(crbr_pkg::REG_TIMEOUT_TICKS, 16'd2000);
        4, 5, 6, 7: write_reg(crbr_pkg::REG_TIMEOUT_TICKS, 16'($urandom_range(2, 12)));
        default: write_reg(crbr_pkg::REG_TIMEOUT_TICKS, 16'($urandom_range(100, 3000)));
      endcase
    end
    if ($urandom_range(1)) begin
      write_reg(crbr_pkg::REG_MAX_TRIES, 16'($urandom_range(7)));
    end
    for (int k = int'(crbr_pkg::REG_READY_CODE); k <= int'(crbr_pkg::REG_TIMEOUT_ABORT_CODE);
         k++) begin
      if ($urandom_range(1)) begin
        write_reg(CFG_AW'(k), 16'(rand_byte()));
      end
    end
  endtask

  task automatic push_block();
    int          len;
    int          lim;
    bit          good;
    logic [15:0] c;
    logic [7:0]  d;
    logic [7:0]  flip;
    len = payload_len();
    lim = (tries_max == 3'd0) ? 1 : int'(tries_max);
    add_item(crbr_pkg::OP_START, rand_byte(), 10'($urandom_range(1023)));
    if (len > 64) begin
      // Long blocks are only begun here and left open.
      repeat ($urandom_range(1, 30)) begin
        if ($urandom_range(9) == 0) begin
          add_read();
        end else begin
          add_item(crbr_pkg::OP_BYTE, rand_byte(), 10'($urandom_range(1023)));
        end
      end
      return;
    end
    for (int a = 0; a < lim; a++) begin
      c = crbr_pkg::CRC_INIT;
      for (int i = 0; i < len; i++) begin
        d = rand_byte();
        c = crc_step(c, d);
        add_item(crbr_pkg::OP_BYTE, d, 10'($urandom_range(1023)));
        if ($urandom_range(99) < 3) begin
          add_item(crbr_pkg::OP_TICK, rand_byte(), 10'($urandom_range(1023)));
        end
        if ($urandom_range(99) < 2) begin
          add_read();
        end
      end
      good = ($urandom_range(2) == 0) || (a == lim - 1 && $urandom_range(1) == 0);
      flip = good ? 8'h00 : 8'($urandom_range(1, 255));
      if ($urandom_range(1)) begin
        c[15:8] = c[15:8] ^ flip;
      end else begin
        c[7:0] = c[7:0] ^ flip;
      end
      add_item(crbr_pkg::OP_BYTE, c[15:8], 10'($urandom_range(1023)));
      add_item(crbr_pkg::OP_BYTE, c[7:0], 10'($urandom_range(1023)));
      if (good) begin
        break;
      end
    end
  endtask

  task automatic push_timeout();
    int n;
    n = $urandom_range(0, (payload_len() + 1 < 8) ? payload_len() + 1 : 8);
    add_item(crbr_pkg::OP_START, rand_byte(), 10'($urandom_range(1023)));
    repeat (n) add_item(crbr_pkg::OP_BYTE, rand_byte(), 10'($urandom_range(1023)));
    repeat ((tmo == 16'd0) ? 1 : int'(tmo)) begin
      add_item(crbr_pkg::OP_TICK, rand_byte(), 10'($urandom_range(1023)));
    end
  endtask

  task automatic push_noise();
    crbr_pkg::op_e op;
    repeat ($urandom_range(8, 30)) begin
      op = crbr_pkg::op_e'($urandom_range(3));
      if (op == crbr_pkg::OP_READ) begin
        add_read();
      end else begin
        add_item(op, rand_byte(), 10'($urandom_range(1023)));
      end
    end
  endtask

  initial begin
    logic [15:0] c;
    int          iter;
    int          r;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(crbr_pkg::REG_BLOCK_LENGTH, 16'd2);
    write_reg(crbr_pkg::REG_TIMEOUT_TICKS, 16'd3);
    write_reg(crbr_pkg::REG_MAX_TRIES, 16'd2);
    write_reg(crbr_pkg::REG_READY_CODE, 16'h00A5);
    write_reg(crbr_pkg::REG_REPEAT_CODE, 16'h005A);
    write_reg(crbr_pkg::REG_ABORT_CODE, 16'h00FF);
    write_reg(crbr_pkg::REG_TIMEOUT_ABORT_CODE, 16'h00C3);

    // Idle input, a bad then a good block, read-back, try-limit abort, timeout.
    add_item(crbr_pkg::OP_BYTE, 8'hFF, 10'h3FF);
    add_item(crbr_pkg::OP_TICK, 8'h00, 10'h000);
    add_item(crbr_pkg::OP_START, 8'h00, 10'h000);
    c = crc_step(crc_step(crbr_pkg::CRC_INIT, 8'h00), 8'hFF);
    add_item(crbr_pkg::OP_BYTE, 8'h00, 10'h000);
    add_item(crbr_pkg::OP_BYTE, 8'hFF, 10'h3FF);
    add_item(crbr_pkg::OP_BYTE, c[15:8], 10'h000);
    add_item(crbr_pkg::OP_BYTE, c[7:0] ^ 8'h01, 10'h000);
    add_item(crbr_pkg::OP_TICK, 8'h00, 10'h000);
    add_item(crbr_pkg::OP_TICK, 8'h00, 10'h000);
    c = crc_step(crc_step(crbr_pkg::CRC_INIT, 8'h12), 8'h34);
    add_item(crbr_pkg::OP_BYTE, 8'h12, 10'h000);
    add_item(crbr_pkg::OP_BYTE, 8'h34, 10'h000);
    add_item(crbr_pkg::OP_BYTE, c[15:8], 10'h000);
    add_item(crbr_pkg::OP_BYTE, c[7:0], 10'h000);
    add_item(crbr_pkg::OP_READ, 8'h00, 10'h000);
    add_item(crbr_pkg::OP_READ, 8'hFF, 10'h001);
    add_item(crbr_pkg::OP_START, 8'hFF, 10'h3FF);
    repeat (2) begin
      add_item(crbr_pkg::OP_BYTE, 8'h55, 10'h000);
      add_item(crbr_pkg::OP_BYTE, 8'hAA, 10'h000);
      add_item(crbr_pkg::OP_BYTE, 8'h00, 10'h000);
      add_item(crbr_pkg::OP_BYTE, 8'h00, 10'h000);
    end
    add_item(crbr_pkg::OP_START, 8'h00, 10'h000);
    repeat (3) add_item(crbr_pkg::OP_TICK, 8'h00, 10'h000);
    settle();
    phases++;

    gen_count = 0;
    iter = 0;
    while (gen_count < RANDOM_ITEMS) begin
      iter++;
      phases++;
      if (iter == 3) begin
        // One long block with good CRC and no idling on either side.
        settle();
        write_reg(crbr_pkg::REG_BLOCK_LENGTH, 16'(LONG_LEN));
        write_reg(crbr_pkg::REG_TIMEOUT_TICKS, 16'hFFFF);
        src_idle_pct = 0;
        sink_idle_pct = 0;
        add_item(crbr_pkg::OP_START, rand_byte(), 10'($urandom_range(1023)));
        c = crbr_pkg::CRC_INIT;
        for (int i = 0; i < LONG_LEN; i++) begin
          r = $urandom_range(255);
          c = crc_step(c, 8'(r));
          add_item(crbr_pkg::OP_BYTE, 8'(r), 10'($urandom_range(1023)));
        end
        add_item(crbr_pkg::OP_BYTE, c[15:8], 10'h000);
        add_item(crbr_pkg::OP_BYTE, c[7:0], 10'h000);
        settle();
        src_idle_pct = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
      end else if (iter == 6) begin
        // The output is held off while reads keep coming, so the input stalls.
        settle();
        src_idle_pct = 0;
        hold_req = 1'b1;
        repeat (40) add_read();
        settle();
        src_idle_pct = IDLE_PCT;
      end else begin
        if ($urandom_range(9) < 4) begin
          pick_settings();
        end
        r = $urandom_range(9);
        if (r < 6) begin
          push_block();
        end else if (r < 8 && tmo <= 16'd40) begin
          push_timeout();
        end else begin
          push_noise();
        end
        while (word_q.size() > QUEUE_AHEAD) begin
          @(posedge clk_i);
        end
      end
    end
    settle();

    $display("Run covered %0d words in, %0d result words checked, %0d phases.",
             words_in, results_seen, phases);
    $display("Register writes: %0d; mismatches: %0d.", reg_writes, fails);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### crc_checked_block_receiver_core.f
+incdir+rtl/core
rtl/core/crbr_pkg.sv
rtl/core/crbr_store.sv
rtl/core/crbr_ctrl.sv
rtl/core/crbr_out.sv
rtl/core/crc_checked_block_receiver_core.sv
tb/tb_crc_checked_block_receiver_core.sv
